// File: rtl/mwd_pkg.sv
// Package of the moving-window deconvolution filter: widths, reset values,
// register indexes, the configuration struct and the sequencer states.
// No dependencies; mwd_cfg_regs and the top level import it.
package mwd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_W      = 16;
  localparam int DATA_W      = 48;
  localparam int SUM_W       = 58;
  localparam int COEF_W      = 25;
  localparam int DLEN_W      = 12;
  localparam int ALEN_W      = 11;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 25;
  localparam int MUL_A_W     = 32;
  localparam int MUL_W       = MUL_A_W + COEF_W;
  localparam int RES_W       = 60;

  localparam int MAX_DIFF_DEF = 2048;
  localparam int MAX_AVG_DEF  = 1024;

  localparam logic [COEF_W-1:0] DECAY_RST     = COEF_W'(16776168);
  localparam logic [DLEN_W-1:0] DIFF_LEN_RST  = DLEN_W'(1000);
  localparam logic [ALEN_W-1:0] AVG_LEN_RST   = ALEN_W'(500);
  localparam logic [COEF_W-1:0] AVG_RECIP_RST = COEF_W'(33554);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECAY     = 4'd0,
    REG_DIFF_LEN  = 4'd1,
    REG_AVG_LEN   = 4'd2,
    REG_AVG_RECIP = 4'd3
  } reg_idx_e;

  typedef struct packed {
    logic [COEF_W-1:0] decay_coef;
    logic [DLEN_W-1:0] diff_length;
    logic [ALEN_W-1:0] avg_length;
    logic [COEF_W-1:0] avg_recip;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECONV,
    ST_DIFF,
    ST_SUM,
    ST_MAG,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SCALE,
    ST_EMIT
  } mwd_state_e;

endpackage

// File: rtl/mwd_hist_mem.sv
// History memory of the filter: one write port, one read port, registered
// read data, valid in the cycle after the read. Depends on nothing.
module mwd_hist_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mwd_cfg_regs.sv
// Configuration register file of the filter: decodes register writes and
// holds the four settings. Depends on mwd_pkg.
module mwd_cfg_regs
  import mwd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_DECAY:     cfg_d.decay_coef  = cfg_data_i[COEF_W-1:0];
        REG_DIFF_LEN:  cfg_d.diff_length = cfg_data_i[DLEN_W-1:0];
        REG_AVG_LEN:   cfg_d.avg_length  = cfg_data_i[ALEN_W-1:0];
        REG_AVG_RECIP: cfg_d.avg_recip   = cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decay_coef  <= DECAY_RST;
      cfg_q.diff_length <= DIFF_LEN_RST;
      cfg_q.avg_length  <= AVG_LEN_RST;
      cfg_q.avg_recip   <= AVG_RECIP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/moving_window_deconvolution_filter.sv
// Top level of the moving-window deconvolution filter: sequencer, datapath
// and the two history memories. Depends on mwd_pkg, mwd_cfg_regs and
// mwd_hist_mem.
//
// Usage. Samples arrive on the s_axis channel, one signed ADC sample per
// beat in tdata and the record-start flag in tuser. Each beat yields exactly
// one result beat on the m_axis channel: the filter output in tdata (signed,
// 16 fraction bits, saturated if averaged) and in tuser a flag set when the
// value is a full window average and clear when it is the raw difference.
// Settings are written through the cfg channel (index and data) while the
// block is idle; the write is taken in the cycle it is offered.
//
// Timing. An item is worked through in sequence: the history memories are
// read in the accept cycle, then deconvolution, differentiation with the
// write-back of the deconvolution history, and the window sum with the
// write-back of the difference history follow. During the first L-1
// samples of a record the result goes to the emit state right after the
// sum; otherwise the window average comes first: the magnitude of the
// sum, two passes through the shared 32x25 multiplier and a rounding step.
// A new sample is taken only once the sequencer is back in idle at the end
// of this read-modify-write sequence over the memories.
//
// Reset clears the accumulators, the sample counter and the memory
// pointers; the memories themselves are not cleared, since an entry is
// read only after it has been written within the current record. When the
// receiver stalls, the result stays in the output register and the
// sequencer waits before loading the next one.
module moving_window_deconvolution_filter
  import mwd_pkg::*;
#(
  parameter int MAX_DIFF = MAX_DIFF_DEF,
  parameter int MAX_AVG  = MAX_AVG_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Sample stream.
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [SAMPLE_BITS-1:0] s_axis_tdata_i,   // [15:0] sample
  input  logic                   s_axis_tuser_i,   // [0] record_start
  // Result stream.
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [DATA_W-1:0]      m_axis_tdata_o,   // [47:0] filtered_value
  output logic                   m_axis_tuser_o,   // [0] averaged
  // Configuration writes.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int IDX_CAP = (MAX_DIFF > MAX_AVG) ? MAX_DIFF : MAX_AVG;
  localparam int MW      = $clog2(MAX_DIFF + 1);
  localparam int LW      = $clog2(MAX_AVG + 1);
  localparam int DAW     = $clog2(MAX_DIFF);
  localparam int AAW     = $clog2(MAX_AVG);
  localparam int IW      = $clog2(IDX_CAP + 1);

  localparam logic [RES_W-1:0] NEG_LIM = RES_W'(1) << (DATA_W - 1);
  localparam logic [RES_W-1:0] POS_LIM = NEG_LIM - RES_W'(1);

  cfg_t cfg;

  mwd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Window lengths clamped to the range the memories can serve.
  logic [31:0] dl32, al32;
  logic [MW-1:0] m_w;
  logic [LW-1:0] l_w;

  always_comb begin
    dl32 = 32'(cfg.diff_length);
    al32 = 32'(cfg.avg_length);
    if (dl32 == 32'd0) begin
      m_w = MW'(1);
    end else if (dl32 > 32'(MAX_DIFF)) begin
      m_w = MW'(MAX_DIFF);
    end else begin
      m_w = MW'(dl32);
    end
    if (al32 == 32'd0) begin
      l_w = LW'(1);
    end else if (al32 > 32'(MAX_AVG)) begin
      l_w = LW'(MAX_AVG);
    end else begin
      l_w = LW'(al32);
    end
  end

  mwd_state_e state_q, state_d;

  // State that survives between samples.
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic [DATA_W-1:0]             acc_q, acc_d;
  logic [SUM_W-1:0]              sum_q, sum_d;
  logic [IW-1:0]                 idx_q;
  logic [DAW-1:0]                dptr_q;
  logic [AAW-1:0]                aptr_q;
  logic                          out_valid_q;

  // Per-sample working registers.
  logic [SAMPLE_BITS-1:0] x_q;
  logic                   pneg_q, use_d_q, use_a_q, avg_q, sneg_q, res_avg_q;
  logic [MUL_W-1:0]       prod_q, lo_q;
  logic [SUM_W-1:0]       mag_q;
  logic [DATA_W-1:0]      d_q, res_q, out_data_q;
  logic                   out_avg_q;

  // Control outputs of the sequencer.
  logic accept, out_free, dmem_we, amem_we;
  logic [MUL_A_W-1:0] mul_a;
  logic [COEF_W-1:0]  mul_b;
  logic [MUL_W-1:0]   mul_p;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Accept-cycle values: record start clears the history first.
  logic               start;
  logic [31:0]        i32;
  logic [SAMPLE_BITS:0] pext, pmag;
  logic [DAW-1:0]     drd;
  logic [AAW-1:0]     ard;
  logic [IW-1:0]      idx_next;

  always_comb begin
    start = s_axis_tuser_i;
    i32   = start ? 32'd0 : 32'(idx_q);
    pext  = start ? '0 : {prev_q[SAMPLE_BITS-1], prev_q};
    pmag  = pext[SAMPLE_BITS] ? (~pext + 1'b1) : pext;
    if (32'(dptr_q) >= 32'(m_w)) begin
      drd = DAW'(32'(dptr_q) - 32'(m_w));
    end else begin
      drd = DAW'(32'(dptr_q) + 32'(MAX_DIFF) - 32'(m_w));
    end
    if (32'(aptr_q) >= 32'(l_w)) begin
      ard = AAW'(32'(aptr_q) - 32'(l_w));
    end else begin
      ard = AAW'(32'(aptr_q) + 32'(MAX_AVG) - 32'(l_w));
    end
    idx_next = (i32 < 32'(IDX_CAP)) ? IW'(i32 + 32'd1) : IW'(i32);
  end

  logic [DATA_W-1:0] dh_rdata, ah_rdata;

  mwd_hist_mem #(
    .DEPTH (MAX_DIFF),
    .WIDTH (DATA_W)
  ) u_deconv_hist (
    .clk_i   (clk_i),
    .we_i    (dmem_we),
    .waddr_i (dptr_q),
    .wdata_i (acc_q),
    .re_i    (accept),
    .raddr_i (drd),
    .rdata_o (dh_rdata)
  );

  mwd_hist_mem #(
    .DEPTH (MAX_AVG),
    .WIDTH (DATA_W)
  ) u_diff_hist (
    .clk_i   (clk_i),
    .we_i    (amem_we),
    .waddr_i (aptr_q),
    .wdata_i (d_q),
    .re_i    (accept),
    .raddr_i (ard),
    .rdata_o (ah_rdata)
  );

  // Shared unsigned multiplier.
  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  // Datapath arithmetic of the individual steps.
  logic [MUL_W-1:0]   kx_full;
  logic [DATA_W-1:0]  kx, xs, a_d, d_d;
  logic [SUM_W-1:0]   mag_d;
  logic [MUL_W:0]     lo_rnd;
  logic [RES_W-1:0]   res_wide, res_sat;
  logic [DATA_W-1:0]  scale_d;

  always_comb begin
    kx_full = (prod_q + MUL_W'(128)) >> 8;
    kx      = kx_full[DATA_W-1:0];
    xs      = {{(DATA_W - SAMPLE_BITS - FRAC_W){x_q[SAMPLE_BITS-1]}}, x_q, {FRAC_W{1'b0}}};
    a_d     = pneg_q ? (xs + kx + acc_q) : (xs - kx + acc_q);
    d_d     = use_d_q ? (acc_q - dh_rdata) : acc_q;
    sum_d   = sum_q + {{(SUM_W - DATA_W){d_q[DATA_W-1]}}, d_q}
              - (use_a_q ? {{(SUM_W - DATA_W){ah_rdata[DATA_W-1]}}, ah_rdata} : '0);
    mag_d   = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
    lo_rnd  = {1'b0, lo_q} + (MUL_W + 1)'(1 << 23);
    res_wide = (RES_W'(prod_q) << 8) + RES_W'(lo_rnd >> 24);
    if (sneg_q) begin
      res_sat = (res_wide > NEG_LIM) ? NEG_LIM : res_wide;
      scale_d = DATA_W'(0) - res_sat[DATA_W-1:0];
    end else begin
      res_sat = (res_wide > POS_LIM) ? POS_LIM : res_wide;
      scale_d = res_sat[DATA_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_axis_tvalid_i) state_d = ST_DECONV;
      ST_DECONV: state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_SUM;
      ST_SUM:    state_d = avg_q ? ST_MAG : ST_EMIT;
      ST_MAG:    state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_EMIT;
      ST_EMIT:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    dmem_we         = 1'b0;
    amem_we         = 1'b0;
    mul_a           = MUL_A_W'(pmag);
    mul_b           = cfg.decay_coef;
    unique case (state_q)
      ST_IDLE:   s_axis_tready_o = 1'b1;
      ST_DIFF:   dmem_we = 1'b1;
      ST_SUM:    amem_we = 1'b1;
      ST_MUL_LO: begin
        mul_a = mag_q[MUL_A_W-1:0];
        mul_b = cfg.avg_recip;
      end
      ST_MUL_HI: begin
        mul_a = MUL_A_W'(mag_q[SUM_W-1:MUL_A_W]);
        mul_b = cfg.avg_recip;
      end
      default: ;
    endcase
  end

  // Accumulators, counters and pointers.
  always_comb begin
    acc_d = acc_q;
    if (accept && start) begin
      acc_d = '0;
    end else if (state_q == ST_DECONV) begin
      acc_d = a_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      acc_q       <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      dptr_q      <= '0;
      aptr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      if (accept) begin
        prev_q <= $signed(s_axis_tdata_i);
        idx_q  <= idx_next;
        if (start) begin
          sum_q <= '0;
        end
      end
      if (dmem_we) begin
        dptr_q <= (dptr_q == DAW'(MAX_DIFF - 1)) ? '0 : dptr_q + 1'b1;
      end
      if (amem_we) begin
        aptr_q <= (aptr_q == AAW'(MAX_AVG - 1)) ? '0 : aptr_q + 1'b1;
        sum_q  <= sum_d;
      end
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the current sample and the output register.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          x_q     <= s_axis_tdata_i;
          pneg_q  <= pext[SAMPLE_BITS];
          prod_q  <= mul_p;
          use_d_q <= i32 >= 32'(m_w);
          use_a_q <= i32 >= 32'(l_w);
          avg_q   <= (i32 + 32'd1) >= 32'(l_w);
        end
      end
      ST_DIFF: d_q <= d_d;
      ST_SUM: begin
        res_q     <= d_q;
        res_avg_q <= 1'b0;
      end
      ST_MAG: begin
        mag_q  <= mag_d;
        sneg_q <= sum_q[SUM_W-1];
      end
      ST_MUL_LO: lo_q <= mul_p;
      ST_MUL_HI: prod_q <= mul_p;
      ST_SCALE: begin
        res_q     <= scale_d;
        res_avg_q <= 1'b1;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_data_q <= res_q;
          out_avg_q  <= res_avg_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_avg_q;

`ifndef SYNTHESIS
  // An accepted sample starts the sequence on the next edge.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_DECONV)
    else $error("accepted sample did not start processing");

  // A result leaving the sequencer always lands in the output register.
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free) |=> m_axis_tvalid_o)
    else $error("emitted result not presented on the output");

  // Circular buffer pointers stay inside their memories.
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(dptr_q) < 32'(MAX_DIFF)) && (32'(aptr_q) < 32'(MAX_AVG)))
    else $error("history pointer out of range");

  // The sample counter saturates at the larger window limit.
  a_idx_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(idx_q) <= 32'(IDX_CAP))
    else $error("sample counter beyond its cap");
`endif

endmodule
